[sv/sha_md_pkg.sv]
// Package for the SHA-256 message digest unit: round constants, initial hash,
// shared command and status structs and the rotate-right function.
// No dependencies.
package sha_md_pkg;

    typedef logic [31:0] t_word;

    typedef struct packed {
        logic        load_byte;
        logic [7:0]  byte_val;
        logic        pad_start;
        logic        zero_fill;
        logic        len_write;
        logic        comp_start;
        logic        round_step;
        logic        comp_finish;
        logic        chain_reset;
        logic        out_shift;
    } t_cmd;

    typedef struct packed {
        logic [5:0]  fill;
        logic        round_last;
        logic        fill_full;
    } t_status;

    localparam t_word INIT_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam t_word ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [5:0] LEN_POS  = 6'd56;

    function automatic t_word rotr(input t_word x, input int unsigned n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

endpackage

[sv/sha_md_if.sv]
// Valid/ready channel interface carrying a generic payload.
// Depends on nothing.
interface sha_md_if #(
    parameter int unsigned PAYLOAD_W = 10
);
    logic                 valid;
    logic                 ready;
    logic [PAYLOAD_W-1:0] payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

[sv/sha_md_datapath.sv]
// Datapath: block buffer, message schedule, working variables, chaining hash
// and digest output shift register. Depends on sha_md_pkg.
module sha_md_datapath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  sha_md_pkg::t_cmd    i_cmd,
    output sha_md_pkg::t_status o_status,
    output sha_md_pkg::t_word   o_digest_word
);
    import sha_md_pkg::*;

    t_word       r_buf [16];
    logic [5:0]  r_fill;
    logic        r_full;
    logic [63:0] r_bits;
    logic [5:0]  r_round;
    t_word       r_w  [16];
    t_word       r_v  [8];
    t_word       r_h  [8];

    t_word w_t, w_new, s0, s1, t1, t2, ch, maj, e1, a0;

    assign o_status.fill       = r_fill;
    assign o_status.fill_full  = r_full;
    assign o_status.round_last = (r_round == 6'd63);
    assign o_digest_word       = r_h[0];

    always_comb begin
        s0 = rotr(r_w[1], 7) ^ rotr(r_w[1], 18) ^ (r_w[1] >> 3);
        s1 = rotr(r_w[14], 17) ^ rotr(r_w[14], 19) ^ (r_w[14] >> 10);
        w_new = r_w[0] + s0 + r_w[9] + s1;
        if (r_round < 6'd16) begin
            w_t = r_buf[r_round[3:0]];
        end else begin
            w_t = w_new;
        end
        e1  = rotr(r_v[4], 6) ^ rotr(r_v[4], 11) ^ rotr(r_v[4], 25);
        ch  = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
        t1  = r_v[7] + e1 + ch + ROUND_K[r_round] + w_t;
        a0  = rotr(r_v[0], 2) ^ rotr(r_v[0], 13) ^ rotr(r_v[0], 22);
        maj = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
        t2  = a0 + maj;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill  <= '0;
            r_full  <= 1'b0;
            r_bits  <= '0;
            r_round <= '0;
            for (int i = 0; i < 8; i++) begin
                r_h[i] <= INIT_HASH[i];
            end
        end else begin
            if (i_cmd.load_byte) begin
                r_buf[r_fill[5:2]][{~r_fill[1:0], 3'b000} +: 8] <= i_cmd.byte_val;
                r_fill        <= r_fill + 6'd1;
                r_full        <= (r_fill == 6'd63);
                r_bits        <= r_bits + 64'd8;
            end
            if (i_cmd.pad_start) begin
                r_buf[r_fill[5:2]][{~r_fill[1:0], 3'b000} +: 8] <= PAD_BYTE;
                r_fill        <= r_fill + 6'd1;
                r_full        <= (r_fill == 6'd63);
            end
            if (i_cmd.zero_fill) begin
                r_buf[r_fill[5:2]][{~r_fill[1:0], 3'b000} +: 8] <= 8'h00;
                r_fill        <= r_fill + 6'd1;
                r_full        <= (r_fill == 6'd63);
            end
            if (i_cmd.len_write) begin
                r_buf[14] <= r_bits[63:32];
                r_buf[15] <= r_bits[31:0];
                r_full <= 1'b1;
            end
            if (i_cmd.comp_start) begin
                r_round <= '0;
                r_full  <= 1'b0;
                r_fill  <= '0;
                for (int i = 0; i < 8; i++) begin
                    r_v[i] <= r_h[i];
                end
            end
            if (i_cmd.round_step) begin
                r_round <= r_round + 6'd1;
                for (int i = 0; i < 15; i++) begin
                    r_w[i] <= r_w[i+1];
                end
                r_w[15] <= w_t;
                r_v[7] <= r_v[6];
                r_v[6] <= r_v[5];
                r_v[5] <= r_v[4];
                r_v[4] <= r_v[3] + t1;
                r_v[3] <= r_v[2];
                r_v[2] <= r_v[1];
                r_v[1] <= r_v[0];
                r_v[0] <= t1 + t2;
            end
            if (i_cmd.comp_finish) begin
                for (int i = 0; i < 8; i++) begin
                    r_h[i] <= r_h[i] + r_v[i];
                end
            end
            if (i_cmd.out_shift && !i_cmd.chain_reset) begin
                for (int i = 0; i < 7; i++) begin
                    r_h[i] <= r_h[i+1];
                end
                r_h[7] <= r_h[0];
            end
            if (i_cmd.chain_reset) begin
                for (int i = 0; i < 8; i++) begin
                    r_h[i] <= INIT_HASH[i];
                end
                r_bits <= '0;
                r_fill <= '0;
                r_full <= 1'b0;
            end
        end
    end
endmodule

[sv/sha_md_ctrl.sv]
// Controller state machine: input handshake, padding sequence, compression
// rounds and digest output. Depends on sha_md_pkg.
module sha_md_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic [7:0]          i_msg_byte,
    input  logic                i_has_byte,
    input  logic                i_end_of_message,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [2:0]          o_word_index,
    output logic                o_last_word,
    output sha_md_pkg::t_cmd    o_cmd,
    input  sha_md_pkg::t_status i_status
);
    import sha_md_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_PAD   = 7'b0000010,
        S_ZERO  = 7'b0000100,
        S_START = 7'b0001000,
        S_ROUND = 7'b0010000,
        S_FIN   = 7'b0100000,
        S_OUT   = 7'b1000000
    } t_state;

    t_state     r_state, n_state;
    logic       r_pend_end, n_pend_end;
    logic       r_final, n_final;
    logic [2:0] r_idx, n_idx;

    assign o_in_ready   = (r_state == S_IDLE);
    assign o_out_valid  = (r_state == S_OUT);
    assign o_word_index = r_idx;
    assign o_last_word  = (r_idx == 3'd7);

    always_comb begin
        n_state    = r_state;
        n_pend_end = r_pend_end;
        n_final    = r_final;
        n_idx      = r_idx;
        o_cmd      = '0;
        o_cmd.byte_val = i_msg_byte;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_byte = i_has_byte;
                    n_pend_end = i_end_of_message;
                    if (i_has_byte && i_status.fill == 6'd63) begin
                        n_final = 1'b0;
                        n_state = S_START;
                    end else if (i_end_of_message) begin
                        n_state = S_PAD;
                    end
                end
            end
            S_PAD: begin
                o_cmd.pad_start = 1'b1;
                n_pend_end = 1'b0;
                if (i_status.fill == 6'd63) begin
                    n_final = 1'b0;
                    n_state = S_START;
                end else begin
                    n_state = S_ZERO;
                end
            end
            S_ZERO: begin
                if (i_status.fill_full) begin
                    n_final = 1'b0;
                    n_state = S_START;
                end else if (i_status.fill == LEN_POS) begin
                    o_cmd.len_write = 1'b1;
                    n_final = 1'b1;
                    n_state = S_START;
                end else begin
                    o_cmd.zero_fill = 1'b1;
                end
            end
            S_START: begin
                o_cmd.comp_start = 1'b1;
                n_state = S_ROUND;
            end
            S_ROUND: begin
                o_cmd.round_step = 1'b1;
                if (i_status.round_last) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                o_cmd.comp_finish = 1'b1;
                if (r_final) begin
                    n_idx   = '0;
                    n_state = S_OUT;
                end else if (r_pend_end) begin
                    n_state = S_PAD;
                end else if (i_status.fill == 6'd0 && r_idx == 3'd1) begin
                    n_state = S_ZERO;
                end else begin
                    n_state = S_ZERO;
                end
                if (!r_final && !r_pend_end) begin
                    n_state = (r_idx == 3'd1) ? S_ZERO : S_IDLE;
                end
            end
            S_OUT: begin
                if (i_out_ready) begin
                    o_cmd.out_shift = 1'b1;
                    n_idx = r_idx + 3'd1;
                    if (r_idx == 3'd7) begin
                        o_cmd.chain_reset = 1'b1;
                        n_final = 1'b0;
                        n_idx   = '0;
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
        // A pad compression that is not final continues with zero fill.
        if (r_state == S_PAD || (r_state == S_ZERO && n_state == S_START && !n_final)) begin
            n_idx = 3'd1;
        end
        if (r_state == S_FIN && !r_final && !r_pend_end && r_idx == 3'd1) begin
            n_idx = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_pend_end <= 1'b0;
            r_final    <= 1'b0;
            r_idx      <= '0;
        end else begin
            r_state    <= n_state;
            r_pend_end <= n_pend_end;
            r_final    <= n_final;
            r_idx      <= n_idx;
        end
    end
endmodule

[sv/sha256_message_digest_unit.sv]
// SHA-256 message digest unit: streams bytes in, emits eight digest words.
// The input and output channels use sha_md_if, with valid and ready.
// Input payload is {end_of_message, has_byte, msg_byte}, 10 bits.
// Output payload is {last_word, word_index, digest_word}, 36 bits.
// A byte beat that does not fill the block is taken and the unit stays idle.
// A beat that completes a 64-byte block starts a compression:
// one load step, 64 rounds of the single round unit and one add-back.
// A closing beat pads the block one byte per cycle, runs one or two
// compressions and then offers eight digest beats, word 0 first.
// Input ready is low while padding, compressing or emitting the digest.
// A stalled output holds its word until the receiver takes it.
// After word 7 the chaining hash, bit count and fill return to their
// reset values, ready for the next message.
// Synchronous active-low reset loads the initial hash and clears counts.
module sha256_message_digest_unit (
    input  logic     i_clk,
    input  logic     i_rst_n,
    sha_md_if.sink   i_in,
    sha_md_if.source o_out
);
    import sha_md_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;
    t_word   w_word;
    logic [2:0] w_idx;
    logic       w_last;

    sha_md_ctrl u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in.valid),
        .i_msg_byte       (i_in.payload[7:0]),
        .i_has_byte       (i_in.payload[8]),
        .i_end_of_message (i_in.payload[9]),
        .o_in_ready       (i_in.ready),
        .o_out_valid      (o_out.valid),
        .i_out_ready      (o_out.ready),
        .o_word_index     (w_idx),
        .o_last_word      (w_last),
        .o_cmd            (w_cmd),
        .i_status         (w_status)
    );

    sha_md_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .o_digest_word (w_word)
    );

    assign o_out.payload = {w_last, w_idx, w_word};
endmodule
